// ----- rtl/mhfl_pkg.sv -----
package mhfl_pkg;

   localparam int MAX_BLOCK_DEF  = 8;
   localparam int DATA_WIDTH_DEF = 32;

   // scale factors carry 30 fraction bits; 1/sqrt(1) needs the 31st bit
   localparam int SCALE_SHIFT = 30;
   localparam int SCALE_W     = 31;

   // digit width of the serial multiplier
   localparam int DIGIT_W = 16;

   localparam logic KIND_LOWPASS = 1'b0;
   localparam logic KIND_DETAIL  = 1'b1;

   typedef logic [SCALE_W-1:0] scale_type;

   // round(2^30 / sqrt(n))
   function automatic scale_type lp_scale(input logic [3:0] n);
      scale_type s;
      unique case (n)
         4'd1:    s = 31'd1073741824;
         4'd2:    s = 31'd759250125;
         4'd3:    s = 31'd619925131;
         4'd4:    s = 31'd536870912;
         4'd5:    s = 31'd480191942;
         4'd6:    s = 31'd438353264;
         4'd7:    s = 31'd405836263;
         4'd8:    s = 31'd379625062;
         default: s = '0;
      endcase
      return s;
   endfunction

   // round(2^30 / sqrt(8n))
   function automatic scale_type dt_scale(input logic [3:0] n);
      scale_type s;
      unique case (n)
         4'd1:    s = 31'd379625062;
         4'd2:    s = 31'd268435456;
         4'd3:    s = 31'd219176632;
         4'd4:    s = 31'd189812531;
         4'd5:    s = 31'd169773489;
         4'd6:    s = 31'd154981283;
         4'd7:    s = 31'd143484787;
         4'd8:    s = 31'd134217728;
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

// ----- rtl/mhfl_req_if.sv -----
interface mhfl_req_if #(
   parameter int DATA_WIDTH = mhfl_pkg::DATA_WIDTH_DEF
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] sample;
   logic                  last_of_block;

   modport source (output valid, output sample, output last_of_block, input ready);
   modport sink   (input valid, input sample, input last_of_block, output ready);
endinterface

// ----- rtl/mhfl_rsp_if.sv -----
interface mhfl_rsp_if #(
   parameter int DATA_WIDTH = mhfl_pkg::DATA_WIDTH_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [DATA_WIDTH-1:0] coefficient;
   logic                  last_of_run;
   logic                  overflow_flag;

   modport source (output valid, output kind, output coefficient, output last_of_run,
                   output overflow_flag, input ready);
   modport sink   (input valid, input kind, input coefficient, input last_of_run,
                   input overflow_flag, output ready);
endinterface

// ----- rtl/mhfl_scale.sv -----
module mhfl_scale #(
   parameter int DATA_WIDTH = mhfl_pkg::DATA_WIDTH_DEF,
   parameter int MAG_W      = DATA_WIDTH + 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [MAG_W-1:0]        mag,
   input  logic                    neg,
   input  mhfl_pkg::scale_type     scale,
   output logic                    done,
   output logic [DATA_WIDTH-1:0]   result
);

   localparam int DW     = mhfl_pkg::DIGIT_W;
   localparam int SW     = mhfl_pkg::SCALE_W;
   localparam int SHIFT  = mhfl_pkg::SCALE_SHIFT;
   localparam int ND     = (MAG_W + DW - 1) / DW;
   localparam int SH_W   = ND * DW;
   localparam int PW     = SH_W + SW;
   localparam int QW     = PW - SHIFT;
   localparam int CNT_W  = $clog2(ND + 1);

   localparam logic [1:0] SC_IDLE = 2'd0;
   localparam logic [1:0] SC_MUL  = 2'd1;
   localparam logic [1:0] SC_RND  = 2'd2;

   localparam logic [PW-1:0] HALF    = PW'(1) << (SHIFT - 1);
   localparam logic [QW-1:0] POS_MAX = {{(QW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
   localparam logic [QW-1:0] NEG_MAX = POS_MAX + QW'(1);

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SH_W-1:0]       sh_ff, sh_in;
   logic [PW-1:0]         acc_ff, acc_in;
   mhfl_pkg::scale_type   scale_ff, scale_in;
   logic                  neg_ff, neg_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH-1:0] result_ff, result_in;

   logic [DW-1:0]         digit;
   logic [DW+SW-1:0]      pp;
   logic [PW-1:0]         rnd;
   logic [QW-1:0]         q;
   logic [QW-1:0]         q_neg;

   assign digit = sh_ff[SH_W-1 -: DW];
   assign pp    = digit * scale_ff;
   assign rnd   = acc_ff + HALF;
   assign q     = rnd[PW-1:SHIFT];
   assign q_neg = (q > NEG_MAX) ? (QW'(0) - NEG_MAX) : (QW'(0) - q);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      sh_in     = sh_ff;
      acc_in    = acc_ff;
      scale_in  = scale_ff;
      neg_in    = neg_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               sh_in    = SH_W'(mag);
               acc_in   = '0;
               scale_in = scale;
               neg_in   = neg;
               cnt_in   = CNT_W'(ND);
               state_in = SC_MUL;
            end
         end
         SC_MUL: begin
            // most significant digit first
            acc_in = (acc_ff << DW) + PW'(pp);
            sh_in  = sh_ff << DW;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) state_in = SC_RND;
         end
         SC_RND: begin
            if (neg_ff) result_in = q_neg[DATA_WIDTH-1:0];
            else if (q > POS_MAX) result_in = POS_MAX[DATA_WIDTH-1:0];
            else result_in = q[DATA_WIDTH-1:0];
            done_in  = 1'b1;
            state_in = SC_IDLE;
         end
         default: state_in = SC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff     <= sh_in;
      acc_ff    <= acc_in;
      scale_ff  <= scale_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ----- rtl/masked_haar_forward_lift.sv -----
// Forward Haar lift over masked 2x2x2 blocks, one level.
// req_ch carries one sample per beat with last_of_block marking the end of a
// block of 1 to MAX_BLOCK samples. While a block is still open, each beat is
// taken as it comes and produces nothing. The closing beat starts the
// output run on rsp_ch: one lowpass beat (kind 0), then one detail beat
// (kind 1) per buffered sample in arrival order, the final one flagged by
// last_of_run. overflow_flag is set on every beat of a run whose block got
// more than MAX_BLOCK samples; the extra samples are dropped.
// Each coefficient goes through one shared digit-serial multiplier of
// DIGIT_W-bit digits, ND = ceil((DATA_WIDTH+4)/16) of them (3 at 32 bits):
// the operand is formed, multiplied most significant digit first, rounded
// and saturated, then handed over. The next coefficient starts only after
// the current beat is taken, so a block of n samples yields n+1 result
// beats one at a time. req_ch.ready is low for the whole run. A stall on
// rsp_ch holds the current beat and the run simply waits.
// Reset clears the sample count, running sum and overflow mark; the sample
// buffer is not cleared, only entries written in the current block are read.
module masked_haar_forward_lift #(
   parameter int MAX_BLOCK  = mhfl_pkg::MAX_BLOCK_DEF,
   parameter int DATA_WIDTH = mhfl_pkg::DATA_WIDTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   mhfl_req_if.sink   req_ch,
   mhfl_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);
   localparam int IDX_W = $clog2(MAX_BLOCK);
   localparam int SUM_W = DATA_WIDTH + 3;
   localparam int MAG_W = DATA_WIDTH + 4;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_OPER = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  ovf_ff, ovf_in;
   logic                  kind_ff, kind_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] buf_ff [MAX_BLOCK];
   logic [DATA_WIDTH-1:0] x_sel_ff;

   logic                  accept;
   logic                  has_room;
   logic                  run_last;
   logic [MAG_W-1:0]      x_ext;
   logic [MAG_W-1:0]      sum_ext;
   logic [MAG_W-1:0]      nx;
   logic [MAG_W-1:0]      operand;
   logic                  op_neg;
   logic [MAG_W-1:0]      op_mag;
   mhfl_pkg::scale_type   op_scale;
   logic                  start;
   logic                  done;
   logic [DATA_WIDTH-1:0] coef;

   assign accept   = req_ch.valid && req_ch.ready;
   assign has_room = count_ff < CNT_W'(MAX_BLOCK);
   assign run_last = (kind_ff == mhfl_pkg::KIND_DETAIL) &&
                     ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   assign x_ext   = {{4{x_sel_ff[DATA_WIDTH-1]}}, x_sel_ff};
   assign sum_ext = {sum_ff[SUM_W-1], sum_ff};
   assign nx      = MAG_W'($signed(x_ext) * $signed({{(MAG_W - CNT_W){1'b0}}, count_ff}));

   always_comb begin
      if (kind_ff == mhfl_pkg::KIND_LOWPASS) begin
         operand  = sum_ext;
         op_scale = mhfl_pkg::lp_scale(4'(count_ff));
      end else begin
         operand  = nx - sum_ext;
         op_scale = mhfl_pkg::dt_scale(4'(count_ff));
      end
      op_neg = operand[MAG_W-1];
      op_mag = op_neg ? (MAG_W'(0) - operand) : operand;
   end

   assign start = (state_ff == ST_OPER);

   mhfl_scale #(
      .DATA_WIDTH (DATA_WIDTH),
      .MAG_W      (MAG_W)
   ) u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .mag    (op_mag),
      .neg    (op_neg),
      .scale  (op_scale),
      .done   (done),
      .result (coef)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      ovf_in   = ovf_ff;
      kind_in  = kind_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (has_room) begin
                  sum_in   = sum_ff + {{3{req_ch.sample[DATA_WIDTH-1]}}, req_ch.sample};
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_ch.last_of_block) begin
                  kind_in  = mhfl_pkg::KIND_LOWPASS;
                  idx_in   = '0;
                  state_in = ST_OPER;
               end
            end
         end
         ST_OPER: state_in = ST_WAIT;
         ST_WAIT: if (done) state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ch.ready) begin
               if (run_last) begin
                  // close the block
                  count_in = '0;
                  sum_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  if (kind_ff == mhfl_pkg::KIND_DETAIL) idx_in = idx_ff + IDX_W'(1);
                  kind_in  = mhfl_pkg::KIND_DETAIL;
                  state_in = ST_OPER;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         kind_ff  <= mhfl_pkg::KIND_LOWPASS;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
         kind_ff  <= kind_in;
         idx_ff   <= idx_in;
      end
   end

   // read ahead at the next index so the sample is ready when the operand forms
   always_ff @(posedge clock) begin
      if (accept && has_room) buf_ff[count_ff[IDX_W-1:0]] <= req_ch.sample;
      x_sel_ff <= buf_ff[idx_in];
   end

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = (state_ff == ST_OUT);
   assign rsp_ch.kind          = kind_ff;
   assign rsp_ch.coefficient   = coef;
   assign rsp_ch.last_of_run   = run_last;
   assign rsp_ch.overflow_flag = ovf_ff;

endmodule
